>>> src/cgtc_pkg.sv
// ----------------------------------------------------------------------------
// cgtc_pkg
// Shared types, widths and the control store of the call-graph closure block.
// ----------------------------------------------------------------------------
`default_nettype none

package cgtc_pkg;

  localparam int CNT_W       = 6;    // node_count register width
  localparam int ROW_W       = 5;    // row index field width
  localparam int BITS_W      = 32;   // row bit mask field width
  localparam int IN_TDATA_W  = 40;   // row_index + callee_bits, byte padded
  localparam int OUT_TDATA_W = 72;   // out_row + direct + indirect, byte padded

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  // Step addresses of the control store
  typedef logic [2:0] step_t;
  localparam step_t ST_LOAD   = 3'd0;
  localparam step_t ST_INIT   = 3'd1;
  localparam step_t ST_CLOSE  = 3'd2;
  localparam step_t ST_REWIND = 3'd3;
  localparam step_t ST_EMIT   = 3'd4;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_LAST,
    COND_N_ZERO,
    COND_K_LAST,
    COND_EMIT_LAST
  } cond_t;

  // One control word: datapath strobes plus sequencing
  typedef struct packed {
    logic  accept;  // input channel open
    logic  init;    // mask rows, copy direct into reach
    logic  close;   // one Warshall pivot column, all rows in parallel
    logic  rewind;  // clear node counter
    logic  emit;    // offer one result row
    cond_t cond;    // jump condition
    logic  hold;    // stay on this step while condition is false
    step_t tgt;     // jump target
  } cgtc_uword_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic in_last_fire;
    logic n_zero;
    logic k_last;
    logic emit_last_fire;
  } cgtc_stat_t;

  function automatic cgtc_uword_t cgtc_rom(input step_t step);
    cgtc_uword_t w;
    w = '0;
    unique case (step)
      ST_LOAD: begin
        w.accept = 1'b1; w.cond = COND_IN_LAST;   w.hold = 1'b1; w.tgt = ST_INIT;
      end
      ST_INIT: begin
        w.init   = 1'b1; w.cond = COND_N_ZERO;    w.hold = 1'b0; w.tgt = ST_LOAD;
      end
      ST_CLOSE: begin
        w.close  = 1'b1; w.cond = COND_K_LAST;    w.hold = 1'b1; w.tgt = ST_REWIND;
      end
      ST_REWIND: begin
        w.rewind = 1'b1; w.cond = COND_ALWAYS;    w.hold = 1'b0; w.tgt = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit   = 1'b1; w.cond = COND_EMIT_LAST; w.hold = 1'b1; w.tgt = ST_LOAD;
      end
      default: begin
        w.cond = COND_ALWAYS; w.hold = 1'b0; w.tgt = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/call_graph_transitive_closure_top.sv
// ----------------------------------------------------------------------------
// call_graph_transitive_closure_top
// Bit-matrix Warshall closure of a call graph, run by a small control store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one adjacency row per transfer. tdata = {callee_bits, row_index},
//           tlast marks the final row and starts the closure.
//   out_* : one result per active node 0..n-1, tdata = {indirect, direct, row},
//           tlast on node n-1. n = node_count saturated to MAX_NODES.
//   cfg_* : node_count write, taken on any cycle with cfg_wr_en high.
// Timing:
//   Rows load one per cycle while the sequencer sits on its load step.
//   After the last row: a mask/copy step, then n pivot updates (one
//   pivot column per cycle, all rows updated in parallel), a rewind step,
//   then n result transfers, one per cycle when out_tready stays high.
//   With n = 0 only the mask/copy step follows the rows.
// Reset: direct rows cleared, node_count = 32, sequencer on the load step.
// Stall: a held result stays in the output register; the emit step waits,
//   and the input stays closed until the last result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module call_graph_transitive_closure_top
  import cgtc_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input rows
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] row_index, [36:5] callee_bits
  input  wire logic                   in_tlast,   // last_row
  // results
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [4:0] out_row, [36:5] direct_bits,
                                                  // [68:37] indirect_bits
  output logic                        out_tlast,  // last_out
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CNT_W-1:0]       cfg_wr_data // node_count
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;   // node index width
  localparam int NW = $clog2(MAX_NODES + 1);                      // node count width

  typedef logic [MAX_NODES-1:0] row_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   node_count_r;
  row_t               direct_r [MAX_NODES];   // direct call rows, reset to zero
  row_t               reach_r  [MAX_NODES];   // closure rows, written at init
  logic [IW-1:0]      k_r;                    // pivot / output node counter

  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [BITS_W-1:0]  out_direct_r;
  logic [BITS_W-1:0]  out_indirect_r;
  logic               out_last_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  cgtc_uword_t uw;
  cgtc_stat_t  stat;

  cgtc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uword (uw)
  );

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic [NW-1:0]     n;
  logic [CNT_W-1:0]  n6;
  row_t              mask;
  logic [ROW_W-1:0]  in_row;
  logic [BITS_W-1:0] in_bits;
  logic              in_fire;
  logic              row_ok;
  logic              k_last;
  logic              emit_fire;
  row_t              pivot;
  row_t              k_hot;
  row_t              rd_direct;

  assign n  = (node_count_r > CNT_W'(MAX_NODES)) ? NW'(MAX_NODES) : node_count_r[NW-1:0];
  assign n6 = CNT_W'(n);

  always_comb begin
    for (int b = 0; b < MAX_NODES; b++) begin
      mask[b] = (CNT_W'(b) < n6);
    end
  end

  assign in_row   = in_tdata[ROW_W-1:0];
  assign in_bits  = in_tdata[ROW_W +: BITS_W];
  assign in_tready = uw.accept;
  assign in_fire  = in_tvalid && uw.accept;
  assign row_ok   = (CNT_W'(in_row) < n6);

  assign k_last    = ((CNT_W'(k_r) + CNT_W'(1)) == n6);
  assign emit_fire = uw.emit && (!out_valid_r || out_tready);
  assign pivot     = reach_r[k_r];
  assign rd_direct = direct_r[k_r];
  assign k_hot     = row_t'(1) << k_r;

  assign stat.in_last_fire   = in_fire && in_tlast;
  assign stat.n_zero         = (n == '0);
  assign stat.k_last         = k_last;
  assign stat.emit_last_fire = emit_fire && k_last;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Direct rows: load, and re-mask to n when the closure starts
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        direct_r[i] <= '0;
      end
    end else if (uw.init) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        if (CNT_W'(i) < n6) begin
          direct_r[i] <= direct_r[i] & mask & ~(row_t'(1) << i);
        end
      end
    end else if (in_fire && row_ok) begin
      direct_r[in_row[IW-1:0]] <= in_bits[MAX_NODES-1:0] & mask
                                  & ~(row_t'(1) << in_row[IW-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Reach rows: copy, then one pivot column per cycle over all rows
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (uw.init) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        reach_r[i] <= direct_r[i] & mask & ~(row_t'(1) << i);
      end
    end else if (uw.close) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        if (reach_r[i][k_r]) begin
          reach_r[i] <= reach_r[i] | pivot;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Node counter
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (uw.init || uw.rewind) begin
      k_r <= '0;
    end else if (uw.close || emit_fire) begin
      k_r <= k_r + IW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r      <= ROW_W'(k_r);
      out_direct_r   <= BITS_W'(rd_direct);
      out_indirect_r <= BITS_W'(pivot & ~k_hot & ~rd_direct);
      out_last_r     <= k_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ROW_W - 2*BITS_W){1'b0}},
                       out_indirect_r, out_direct_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> src/cgtc_seq.sv
// ----------------------------------------------------------------------------
// cgtc_seq
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module cgtc_seq
  import cgtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cgtc_stat_t  stat,
  output cgtc_uword_t      uword
);

  step_t step_r;
  step_t step_nxt;
  logic  take;

  assign uword = cgtc_rom(step_r);

  always_comb begin
    unique case (uword.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_IN_LAST:   take = stat.in_last_fire;
      COND_N_ZERO:    take = stat.n_zero;
      COND_K_LAST:    take = stat.k_last;
      COND_EMIT_LAST: take = stat.emit_last_fire;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    priority if (take) begin
      step_nxt = uword.tgt;
    end else if (uword.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire
